/* hw/rtl/pfa_pkg.sv */
package pfa_pkg;

    // sizing
    localparam int NUM_FRAMES     = 65536;
    localparam int NUM_PARTITIONS = 16;
    localparam int FRAME_BYTES    = 4096;
    localparam int WORD_BITS      = 64;

    localparam int NWORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FW       = $clog2(NUM_FRAMES);
    localparam int RW       = $clog2(NWORDS);
    localparam int BW       = $clog2(WORD_BITS);
    localparam int PW       = $clog2(NUM_PARTITIONS);
    localparam int FB_SH    = $clog2(FRAME_BYTES);
    localparam int TAGROW_W = WORD_BITS * PW;
    localparam int NGRP     = WORD_BITS / 8;
    localparam int POP_W    = BW + 1;
    localparam int TOT_W    = FW + 1;

    // field widths
    localparam int KIND_W    = 3;
    localparam int PART_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 17;
    localparam int STAT_W    = 3;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_W     = (FW + 1 > CFG_W) ? FW + 1 : CFG_W;

    localparam logic [CFG_W-1:0] RESERVED_ABOVE_RST = CFG_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BELOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_ABOVE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PART  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVER_QUOTA = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC       = 3'd0,
        K_ALLOC_SYS   = 3'd1,
        K_FREE        = 3'd2,
        K_RECLAIM     = 3'd3,
        K_RESERVE     = 3'd4,
        K_SET_QUOTA   = 3'd5,
        K_RESET_USAGE = 3'd6,
        K_QUERY       = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        PATH_DONE   = 2'd0,
        PATH_SCAN   = 2'd1,
        PATH_SINGLE = 2'd2,
        PATH_RECL   = 2'd3
    } path_t;

    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_CLEAR     = 4'd1,
        DP_LATCH     = 4'd2,
        DP_DECODE    = 4'd3,
        DP_SCAN_EVAL = 4'd4,
        DP_SCAN_NEXT = 4'd5,
        DP_SCAN_FAIL = 4'd6,
        DP_ALLOC     = 4'd7,
        DP_SINGLE    = 4'd8,
        DP_RECL_EVAL = 4'd9,
        DP_RECL_POP  = 4'd10,
        DP_RECL_SUM  = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        path_t path;
        logic  row_last;
        logic  scan_end;
        logic  cand_any;
        logic  out_busy;
    } sts_t;

    // in-window bits of one bitmap word: frames f with lo <= f < hi
    function automatic logic [WORD_BITS-1:0] win_mask(
        input logic [RW-1:0]    row,
        input logic [WIN_W-1:0] lo,
        input logic [WIN_W-1:0] hi
    );
        logic [WIN_W-BW-1:0]   r;
        logic [WIN_W-BW-1:0]   lr;
        logic [WIN_W-BW-1:0]   hr;
        logic [WORD_BITS-1:0]  ones;
        logic [WORD_BITS-1:0]  ml;
        logic [WORD_BITS-1:0]  mh;
        r    = (WIN_W-BW)'(row);
        lr   = lo[WIN_W-1:BW];
        hr   = hi[WIN_W-1:BW];
        ones = '1;
        if (r > lr)
            ml = ones;
        else if (r == lr)
            ml = ones << lo[BW-1:0];
        else
            ml = '0;
        if (r < hr)
            mh = ones;
        else if (r == hr)
            mh = ~(ones << hi[BW-1:0]);
        else
            mh = '0;
        return ml & mh;
    endfunction

    // position of lowest set bit
    function automatic logic [BW-1:0] first_one(input logic [WORD_BITS-1:0] v);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = BW'(i);
        end
        return idx;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

/* hw/rtl/pfa_ctrl.sv */
module pfa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pfa_pkg::sts_t sts,
    output pfa_pkg::cmd_t cmd
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DECODE  = 13'b0000000000100,
        S_SCAN_RD = 13'b0000000001000,
        S_SCAN_EV = 13'b0000000010000,
        S_SCAN_PE = 13'b0000000100000,
        S_SGL_RD  = 13'b0000001000000,
        S_SGL_WR  = 13'b0000010000000,
        S_RC_RD   = 13'b0000100000000,
        S_RC_EV   = 13'b0001000000000,
        S_RC_POP  = 13'b0010000000000,
        S_RC_SUM  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = pfa_pkg::DP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = pfa_pkg::DP_CLEAR;
                if (sts.row_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = pfa_pkg::DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = pfa_pkg::DP_DECODE;
                unique case (sts.path)
                    pfa_pkg::PATH_SCAN:   state_next = S_SCAN_RD;
                    pfa_pkg::PATH_SINGLE: state_next = S_SGL_RD;
                    pfa_pkg::PATH_RECL:   state_next = S_RC_RD;
                    default:              state_next = S_DONE;
                endcase
            end
            S_SCAN_RD: state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                cmd.op     = pfa_pkg::DP_SCAN_EVAL;
                state_next = S_SCAN_PE;
            end
            S_SCAN_PE:
            begin
                if (sts.cand_any)
                begin
                    cmd.op     = pfa_pkg::DP_ALLOC;
                    state_next = S_DONE;
                end
                else if (sts.scan_end)
                begin
                    cmd.op     = pfa_pkg::DP_SCAN_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pfa_pkg::DP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_SGL_RD: state_next = S_SGL_WR;
            S_SGL_WR:
            begin
                cmd.op     = pfa_pkg::DP_SINGLE;
                state_next = S_DONE;
            end
            S_RC_RD: state_next = S_RC_EV;
            S_RC_EV:
            begin
                cmd.op     = pfa_pkg::DP_RECL_EVAL;
                state_next = S_RC_POP;
            end
            S_RC_POP:
            begin
                cmd.op     = pfa_pkg::DP_RECL_POP;
                state_next = S_RC_SUM;
            end
            S_RC_SUM:
            begin
                cmd.op     = pfa_pkg::DP_RECL_SUM;
                state_next = sts.row_last ? S_DONE : S_RC_RD;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // an accepted request always goes to decode next
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_DECODE))
        else $error("accepted request did not reach decode");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over a stalled result");

endmodule

/* hw/rtl/pfa_datapath.sv */
module pfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfa_pkg::cmd_t                 cmd,
    output pfa_pkg::sts_t                 sts,
    input  logic [pfa_pkg::KIND_W-1:0]    kind,
    input  logic [pfa_pkg::PART_W-1:0]    partition,
    input  logic [pfa_pkg::ADDR_W-1:0]    frame_address,
    input  logic [pfa_pkg::CNT_W-1:0]     quota_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [pfa_pkg::STAT_W-1:0]    status,
    output logic [pfa_pkg::ADDR_W-1:0]    frame_out,
    output logic [pfa_pkg::CNT_W-1:0]     count_out,
    output logic [pfa_pkg::CNT_W-1:0]     quota_out,
    output logic [pfa_pkg::CNT_W-1:0]     allocated_total
);

    // memories
    logic [pfa_pkg::WORD_BITS-1:0] bitmap_mem [pfa_pkg::NWORDS];
    logic [pfa_pkg::TAGROW_W-1:0]  tag_mem    [pfa_pkg::NWORDS];
    logic [pfa_pkg::WORD_BITS-1:0] bm_rdata_reg;
    logic [pfa_pkg::TAGROW_W-1:0]  tag_rdata_reg;
    logic                          bm_we;
    logic [pfa_pkg::WORD_BITS-1:0] bm_wdata;
    logic                          tag_we;
    logic [pfa_pkg::TAGROW_W-1:0]  tag_wdata;

    // control state
    logic [pfa_pkg::RW-1:0]    row_ptr_reg;
    logic [pfa_pkg::RW-1:0]    row_ptr_next;
    logic [pfa_pkg::CFG_W-1:0] rb_reg;
    logic [pfa_pkg::CFG_W-1:0] ra_reg;
    logic [pfa_pkg::TOT_W-1:0] total_reg;
    logic [pfa_pkg::TOT_W-1:0] total_next;
    logic                      rsp_valid_reg;
    logic [pfa_pkg::CNT_W-1:0] usage_reg [pfa_pkg::NUM_PARTITIONS];
    logic [pfa_pkg::CNT_W-1:0] quota_reg [pfa_pkg::NUM_PARTITIONS];

    // request and work registers
    pfa_pkg::kind_t              kind_reg;
    logic [pfa_pkg::PART_W-1:0]  part_reg;
    logic [pfa_pkg::ADDR_W-1:0]  addr_reg;
    logic [pfa_pkg::CNT_W-1:0]   qv_reg;
    logic [pfa_pkg::FW-1:0]      tgt_reg;
    logic [pfa_pkg::WORD_BITS-1:0] cand_reg;
    logic [pfa_pkg::WORD_BITS-1:0] mask_reg;
    logic [3:0]                  grp_pop_reg [pfa_pkg::NGRP];
    logic [pfa_pkg::STAT_W-1:0]  res_status_reg;
    logic [pfa_pkg::ADDR_W-1:0]  res_frame_reg;
    logic [pfa_pkg::CNT_W-1:0]   res_count_reg;
    logic [pfa_pkg::CNT_W-1:0]   res_quota_reg;
    logic [pfa_pkg::STAT_W-1:0]  status_reg;
    logic [pfa_pkg::ADDR_W-1:0]  frame_out_reg;
    logic [pfa_pkg::CNT_W-1:0]   count_out_reg;
    logic [pfa_pkg::CNT_W-1:0]   quota_out_reg;
    logic [pfa_pkg::CNT_W-1:0]   total_out_reg;

    // decode
    logic [pfa_pkg::WIN_W-1:0]   lo;
    logic [pfa_pkg::WIN_W-1:0]   hi;
    logic [pfa_pkg::WIN_W-1:0]   hi_m1;
    logic [pfa_pkg::WORD_BITS-1:0] win;
    logic                        part_ok;
    logic [pfa_pkg::PW-1:0]      eff_part;
    logic [pfa_pkg::CNT_W-1:0]   usage_cur;
    logic [pfa_pkg::CNT_W-1:0]   quota_cur;
    logic [pfa_pkg::ADDR_W-1:0]  fi;
    logic                        free_bad;
    logic                        rsv_bad;
    logic                        win_empty;
    logic                        over_quota;
    logic [pfa_pkg::STAT_W-1:0]  dec_status;
    pfa_pkg::path_t              dec_path;
    logic [pfa_pkg::FW-1:0]      dec_tgt;
    logic [pfa_pkg::RW-1:0]      dec_row;
    logic [pfa_pkg::BW-1:0]      alloc_bit;
    logic [pfa_pkg::BW-1:0]      tgt_bit;
    logic                        tgt_hit;
    logic [pfa_pkg::WORD_BITS-1:0] tag_match;
    logic [pfa_pkg::WORD_BITS-1:0] recl_mask;
    logic [pfa_pkg::POP_W-1:0]   pop_sum;
    logic [pfa_pkg::FW-1:0]      alloc_idx;

    function automatic logic [pfa_pkg::ADDR_W-1:0] frame_address_shift(
        input logic [pfa_pkg::ADDR_W-1:0] a
    );
        return a >> pfa_pkg::FB_SH;
    endfunction

    assign cfg_ready = 1'b1;

    assign lo    = (rb_reg == '0) ? pfa_pkg::WIN_W'(1) : pfa_pkg::WIN_W'(rb_reg);
    assign hi    = (pfa_pkg::WIN_W'(ra_reg) < pfa_pkg::WIN_W'(pfa_pkg::NUM_FRAMES))
                   ? pfa_pkg::WIN_W'(ra_reg) : pfa_pkg::WIN_W'(pfa_pkg::NUM_FRAMES);
    assign hi_m1 = hi - pfa_pkg::WIN_W'(1);
    assign win   = pfa_pkg::win_mask(row_ptr_reg, lo, hi);
    assign win_empty = (lo >= hi);

    assign part_ok   = ({1'b0, part_reg} < (pfa_pkg::PART_W+1)'(pfa_pkg::NUM_PARTITIONS));
    assign eff_part  = (kind_reg == pfa_pkg::K_ALLOC_SYS) ? '0 : part_reg[pfa_pkg::PW-1:0];
    assign usage_cur = usage_reg[eff_part];
    assign quota_cur = quota_reg[eff_part];
    assign over_quota = (quota_cur != '0) && (usage_cur >= quota_cur);

    assign fi       = frame_address_shift(addr_reg);
    assign free_bad = (addr_reg[pfa_pkg::FB_SH-1:0] != '0) || (fi == '0)
                   || (fi >= pfa_pkg::ADDR_W'(pfa_pkg::NUM_FRAMES))
                   || (fi < pfa_pkg::ADDR_W'(rb_reg)) || (fi >= pfa_pkg::ADDR_W'(ra_reg));
    assign rsv_bad  = (addr_reg >= pfa_pkg::ADDR_W'(pfa_pkg::NUM_FRAMES));

    always_comb
    begin
        dec_status = pfa_pkg::ST_OK;
        dec_path   = pfa_pkg::PATH_DONE;
        unique case (kind_reg) inside
            pfa_pkg::K_ALLOC:
            begin
                if (!part_ok)
                    dec_status = pfa_pkg::ST_BAD_PART;
                else if (over_quota)
                    dec_status = pfa_pkg::ST_OVER_QUOTA;
                else if (win_empty)
                    dec_status = pfa_pkg::ST_NO_FREE;
                else
                    dec_path = pfa_pkg::PATH_SCAN;
            end
            pfa_pkg::K_ALLOC_SYS:
            begin
                if (win_empty)
                    dec_status = pfa_pkg::ST_NO_FREE;
                else
                    dec_path = pfa_pkg::PATH_SCAN;
            end
            pfa_pkg::K_FREE:
            begin
                if (!part_ok)
                    dec_status = pfa_pkg::ST_BAD_PART;
                else if (free_bad)
                    dec_status = pfa_pkg::ST_BAD_ADDR;
                else
                    dec_path = pfa_pkg::PATH_SINGLE;
            end
            pfa_pkg::K_RECLAIM:
            begin
                if (!part_ok)
                    dec_status = pfa_pkg::ST_BAD_PART;
                else
                    dec_path = pfa_pkg::PATH_RECL;
            end
            pfa_pkg::K_RESERVE:
            begin
                if (rsv_bad)
                    dec_status = pfa_pkg::ST_BAD_ADDR;
                else
                    dec_path = pfa_pkg::PATH_SINGLE;
            end
            pfa_pkg::K_SET_QUOTA, pfa_pkg::K_RESET_USAGE, pfa_pkg::K_QUERY:
            begin
                if (!part_ok)
                    dec_status = pfa_pkg::ST_BAD_PART;
            end
            default: dec_status = pfa_pkg::ST_OK;
        endcase
    end

    assign dec_tgt = (kind_reg == pfa_pkg::K_FREE) ? fi[pfa_pkg::FW-1:0]
                                                    : addr_reg[pfa_pkg::FW-1:0];

    always_comb
    begin
        case (dec_path)
            pfa_pkg::PATH_SCAN:   dec_row = lo[pfa_pkg::BW+pfa_pkg::RW-1:pfa_pkg::BW];
            pfa_pkg::PATH_SINGLE: dec_row = dec_tgt[pfa_pkg::FW-1:pfa_pkg::BW];
            default:              dec_row = '0;
        endcase
    end

    // row operations
    assign alloc_bit = pfa_pkg::first_one(cand_reg);
    assign alloc_idx = {row_ptr_reg, alloc_bit};
    assign tgt_bit   = tgt_reg[pfa_pkg::BW-1:0];
    assign tgt_hit   = bm_rdata_reg[tgt_bit];

    always_comb
    begin
        for (int j = 0; j < pfa_pkg::WORD_BITS; j++)
        begin
            tag_match[j] = (tag_rdata_reg[j*pfa_pkg::PW +: pfa_pkg::PW]
                            == part_reg[pfa_pkg::PW-1:0]);
        end
    end
    assign recl_mask = bm_rdata_reg & win & tag_match;

    always_comb
    begin
        pop_sum = '0;
        for (int g = 0; g < pfa_pkg::NGRP; g++)
        begin
            pop_sum = pop_sum + pfa_pkg::POP_W'(grp_pop_reg[g]);
        end
    end

    always_comb
    begin
        bm_we     = 1'b0;
        bm_wdata  = bm_rdata_reg;
        tag_we    = 1'b0;
        tag_wdata = tag_rdata_reg;
        case (cmd.op)
            pfa_pkg::DP_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_wdata = '0;
            end
            pfa_pkg::DP_ALLOC:
            begin
                bm_we    = 1'b1;
                bm_wdata[alloc_bit] = 1'b1;
                tag_we   = 1'b1;
                tag_wdata[alloc_bit*pfa_pkg::PW +: pfa_pkg::PW] = eff_part;
            end
            pfa_pkg::DP_SINGLE:
            begin
                if (kind_reg == pfa_pkg::K_FREE)
                begin
                    bm_we = tgt_hit;
                    bm_wdata[tgt_bit] = 1'b0;
                end
                else
                begin
                    // reserved frames carry the system tag
                    bm_we  = !tgt_hit;
                    tag_we = !tgt_hit;
                    bm_wdata[tgt_bit] = 1'b1;
                    tag_wdata[tgt_bit*pfa_pkg::PW +: pfa_pkg::PW] = '0;
                end
            end
            pfa_pkg::DP_RECL_EVAL:
            begin
                bm_we    = 1'b1;
                bm_wdata = bm_rdata_reg & ~recl_mask;
            end
            default: bm_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bitmap_mem[row_ptr_reg] <= bm_wdata;
        bm_rdata_reg <= bitmap_mem[row_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[row_ptr_reg] <= tag_wdata;
        tag_rdata_reg <= tag_mem[row_ptr_reg];
    end

    always_comb
    begin
        case (cmd.op) inside
            pfa_pkg::DP_CLEAR, pfa_pkg::DP_SCAN_NEXT, pfa_pkg::DP_RECL_SUM:
                row_ptr_next = row_ptr_reg + pfa_pkg::RW'(1);
            pfa_pkg::DP_DECODE:
                row_ptr_next = dec_row;
            default:
                row_ptr_next = row_ptr_reg;
        endcase
    end

    always_comb
    begin
        total_next = total_reg;
        case (cmd.op)
            pfa_pkg::DP_ALLOC:
                total_next = total_reg + pfa_pkg::TOT_W'(1);
            pfa_pkg::DP_SINGLE:
            begin
                if (kind_reg == pfa_pkg::K_FREE && tgt_hit && total_reg != '0)
                    total_next = total_reg - pfa_pkg::TOT_W'(1);
                else if (kind_reg != pfa_pkg::K_FREE && !tgt_hit)
                    total_next = total_reg + pfa_pkg::TOT_W'(1);
            end
            pfa_pkg::DP_RECL_SUM:
                total_next = total_reg - pfa_pkg::TOT_W'(pop_sum);
            default:
                total_next = total_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ptr_reg   <= '0;
            rb_reg        <= '0;
            ra_reg        <= pfa_pkg::RESERVED_ABOVE_RST;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            row_ptr_reg <= row_ptr_next;
            total_reg   <= total_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfa_pkg::REG_RESERVED_BELOW: rb_reg <= cfg_data;
                    pfa_pkg::REG_RESERVED_ABOVE: ra_reg <= cfg_data;
                    default: rb_reg <= rb_reg;
                endcase
            end
            if (cmd.out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // per-partition tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < pfa_pkg::NUM_PARTITIONS; p++)
            begin
                usage_reg[p] <= '0;
                quota_reg[p] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                pfa_pkg::DP_DECODE:
                begin
                    if (dec_status == pfa_pkg::ST_OK && kind_reg == pfa_pkg::K_SET_QUOTA)
                        quota_reg[eff_part] <= qv_reg;
                    if (dec_status == pfa_pkg::ST_OK && kind_reg == pfa_pkg::K_RESET_USAGE)
                        usage_reg[eff_part] <= '0;
                end
                pfa_pkg::DP_ALLOC:
                begin
                    if (usage_cur != '1)
                        usage_reg[eff_part] <= usage_cur + pfa_pkg::CNT_W'(1);
                end
                pfa_pkg::DP_SINGLE:
                begin
                    if (kind_reg == pfa_pkg::K_FREE && tgt_hit && usage_cur != '0)
                        usage_reg[eff_part] <= usage_cur - pfa_pkg::CNT_W'(1);
                end
                pfa_pkg::DP_RECL_SUM:
                begin
                    if (sts.row_last)
                        usage_reg[eff_part] <= '0;
                end
                default: usage_reg[eff_part] <= usage_cur;
            endcase
        end
    end

    // request, work and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pfa_pkg::DP_LATCH:
            begin
                kind_reg <= pfa_pkg::kind_t'(kind);
                part_reg <= partition;
                addr_reg <= frame_address;
                qv_reg   <= quota_value;
            end
            pfa_pkg::DP_DECODE:
            begin
                tgt_reg        <= dec_tgt;
                res_status_reg <= dec_status;
                res_frame_reg  <= '0;
                res_count_reg  <= '0;
                res_quota_reg  <= '0;
                if (dec_status == pfa_pkg::ST_OK && kind_reg == pfa_pkg::K_QUERY)
                begin
                    res_count_reg <= usage_cur;
                    res_quota_reg <= quota_cur;
                end
            end
            pfa_pkg::DP_SCAN_EVAL:
                cand_reg <= ~bm_rdata_reg & win;
            pfa_pkg::DP_SCAN_FAIL:
                res_status_reg <= pfa_pkg::ST_NO_FREE;
            pfa_pkg::DP_ALLOC:
                res_frame_reg <= pfa_pkg::ADDR_W'(alloc_idx) << pfa_pkg::FB_SH;
            pfa_pkg::DP_SINGLE:
            begin
                if (kind_reg == pfa_pkg::K_FREE && !tgt_hit)
                    res_status_reg <= pfa_pkg::ST_NOT_ALLOC;
            end
            pfa_pkg::DP_RECL_EVAL:
                mask_reg <= recl_mask;
            pfa_pkg::DP_RECL_POP:
            begin
                for (int g = 0; g < pfa_pkg::NGRP; g++)
                begin
                    grp_pop_reg[g] <= pfa_pkg::pop8(mask_reg[g*8 +: 8]);
                end
            end
            pfa_pkg::DP_RECL_SUM:
                res_count_reg <= res_count_reg + pfa_pkg::CNT_W'(pop_sum);
            default: cand_reg <= cand_reg;
        endcase
        if (cmd.out_load)
        begin
            status_reg    <= res_status_reg;
            frame_out_reg <= res_frame_reg;
            count_out_reg <= res_count_reg;
            quota_out_reg <= res_quota_reg;
            total_out_reg <= total_reg[pfa_pkg::CNT_W-1:0];
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign frame_out       = frame_out_reg;
    assign count_out       = count_out_reg;
    assign quota_out       = quota_out_reg;
    assign allocated_total = total_out_reg;

    assign sts.path     = dec_path;
    assign sts.row_last = (row_ptr_reg == pfa_pkg::RW'(pfa_pkg::NWORDS - 1));
    assign sts.scan_end = (row_ptr_reg == hi_m1[pfa_pkg::BW+pfa_pkg::RW-1:pfa_pkg::BW]);
    assign sts.cand_any = (cand_reg != '0);
    assign sts.out_busy = rsp_valid_reg && rsp_stall;

    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= pfa_pkg::TOT_W'(pfa_pkg::NUM_FRAMES))
        else $error("used frame count above frame count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pfa_pkg::DP_ALLOC) |-> ((cand_reg & ~win) == '0))
        else $error("allocation outside the frame window");

endmodule

/* hw/rtl/partitioned_frame_allocator.sv */
// Partitioned page-frame allocator: one used bit per frame in a bitmap memory of
// 64-bit words, a 4-bit owner tag per frame, and per-partition usage counters and quotas.
// A request is taken when req_valid is high and req_stall low; its single result appears
// on the rsp channel and may wait there while the next request is taken. Requests are
// handled one at a time. From acceptance, each request passes decode and then the result
// register: set quota, reset usage, query and any rejected request go straight to it; free and
// reserve add a read and a write state; an allocation reads, evaluates and picks per
// bitmap word scanned, from the word holding the low watermark up to the first word with a free
// in-window frame; a reclaim reads, evaluates, popcounts and sums every bitmap word.
// The bitmap and tag memories have a single read port. After reset a clearing pass writes
// zero to all 1024 bitmap words, one a cycle, and no request is taken until it ends;
// configuration writes are taken at any time and should only be made while idle.
module partitioned_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [pfa_pkg::KIND_W-1:0]    kind,
    input  logic [pfa_pkg::PART_W-1:0]    partition,
    input  logic [pfa_pkg::ADDR_W-1:0]    frame_address,
    input  logic [pfa_pkg::CNT_W-1:0]     quota_value,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [pfa_pkg::STAT_W-1:0]    status,
    output logic [pfa_pkg::ADDR_W-1:0]    frame_out,
    output logic [pfa_pkg::CNT_W-1:0]     count_out,
    output logic [pfa_pkg::CNT_W-1:0]     quota_out,
    output logic [pfa_pkg::CNT_W-1:0]     allocated_total,
    // configuration: index 0 low watermark, index 1 high watermark
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_data
);

    pfa_pkg::cmd_t cmd;
    pfa_pkg::sts_t sts;

    // sequencer
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // bitmap, tags, tables and result register
    pfa_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .kind            (kind),
        .partition       (partition),
        .frame_address   (frame_address),
        .quota_value     (quota_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .frame_out       (frame_out),
        .count_out       (count_out),
        .quota_out       (quota_out),
        .allocated_total (allocated_total)
    );

endmodule
